### sv/ulkd_pkg.sv
// Shared types, keyword table and constants for the UART line keyword decoder.
package ulkd_pkg;

  localparam int KW_COUNT      = 10;
  localparam int KW_MAXLEN     = 24;
  localparam int CNT_W         = 5;
  localparam int MODE_W        = 3;
  localparam int KW_ON         = 0;
  localparam int KW_OFF        = 1;
  localparam int FIRST_MODE_KW = 2;

  localparam logic [7:0]       CHAR_CR   = 8'd13;
  localparam logic [7:0]       CHAR_LF   = 8'd10;
  localparam logic [CNT_W-1:0] CNT_MAX   = 5'd31;
  localparam logic [KW_COUNT-1:0] ALL_FLAGS = {KW_COUNT{1'b1}};

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_ALL_ON  = 2'd1,
    ACT_ALL_OFF = 2'd2
  } action_t;

  typedef logic [KW_MAXLEN*8-1:0] kw_text_t;

  // Text is right-justified: first character sits in the highest used byte.
  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    kw_text_t'("ledallon"),
    kw_text_t'("ledalloff"),
    kw_text_t'("reset"),
    kw_text_t'("ledalltoggle"),
    kw_text_t'({"shift_", "left_ledon"}),
    kw_text_t'({"shift_", "right_ledon"}),
    kw_text_t'({"shift_", "stack_left_ledon"}),
    kw_text_t'({"shift_", "stack_right_ledon"}),
    kw_text_t'({"shift_", "flower_left_ledon"}),
    kw_text_t'({"shift_", "flower_right_ledon"})
  };

  // Prefix length: keyword length minus its last character.
  localparam logic [CNT_W-1:0] KW_PLEN [KW_COUNT] = '{
    5'd7, 5'd8, 5'd4, 5'd11, 5'd15, 5'd16, 5'd21, 5'd22, 5'd22, 5'd23
  };

  typedef struct packed {
    logic              line_end;
    action_t           port_action;
    logic [MODE_W-1:0] led_mode;
    logic              mode_changed;
  } res_t;

  // Character at position pos of keyword k; valid for pos below the prefix length.
  function automatic logic [7:0] kw_char(input int k, input logic [CNT_W-1:0] pos);
    int sh;
    sh = (int'(KW_PLEN[k]) - int'(pos)) * 8;
    if (sh < 0) sh = 0;
    return KW_TEXT[k][sh +: 8];
  endfunction

endpackage

### sv/ulkd_if.sv
// Valid/ready channel interfaces for received bytes and decoded results.
interface ulkd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ulkd_out_if;
  import ulkd_pkg::*;
  logic              valid;
  logic              ready;
  logic              line_end;
  action_t           port_action;
  logic [MODE_W-1:0] led_mode;
  logic              mode_changed;

  modport source (output valid, output line_end, output port_action, output led_mode,
                  output mode_changed, input ready);
  modport sink   (input valid, input line_end, input port_action, input led_mode,
                  input mode_changed, output ready);
endinterface

### sv/ulkd_in_reg.sv
// Input register stage: captures one received byte per item.
module ulkd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  ulkd_in_if.sink    in_ch,
  input  logic       adv,
  output logic       vld,
  output logic [7:0] byte_q
);
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;

  assign in_ch.ready = !vld_r || adv;
  assign vld_nxt     = in_ch.valid || (vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign vld    = vld_r;
  assign byte_q = byte_r;
endmodule

### sv/ulkd_match.sv
// Per-keyword match flags, character count, held mode and line-end evaluation.
module ulkd_match (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic [7:0]    byte_q,
  output ulkd_pkg::res_t res
);
  import ulkd_pkg::*;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [KW_COUNT-1:0] sm_r, sm_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [KW_COUNT-1:0] hit, miss;
  logic                is_end;
  logic                changed;
  action_t             act;

  assign is_end = (byte_q == CHAR_CR) || (byte_q == CHAR_LF);

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      hit[k]  = sm_r[k] && (cnt_r >= KW_PLEN[k]);
      miss[k] = (cnt_r < KW_PLEN[k]) && (byte_q != kw_char(k, cnt_r));
    end
  end

  // Later keywords take priority over earlier ones.
  always_comb begin
    act      = ACT_NONE;
    mode_nxt = mode_r;
    changed  = 1'b0;
    if (is_end) begin
      if (hit[KW_OFF]) begin
        act = ACT_ALL_OFF;
      end else if (hit[KW_ON]) begin
        act = ACT_ALL_ON;
      end
      for (int k = FIRST_MODE_KW; k < KW_COUNT; k++) begin
        if (hit[k]) begin
          mode_nxt = MODE_W'(k - FIRST_MODE_KW);
          changed  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (is_end) begin
      cnt_nxt = '0;
      sm_nxt  = ALL_FLAGS;
    end else begin
      cnt_nxt = (cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
      sm_nxt  = sm_r & ~miss;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sm_r   <= ALL_FLAGS;
      mode_r <= '0;
    end else if (adv) begin
      cnt_r  <= cnt_nxt;
      sm_r   <= sm_nxt;
      mode_r <= mode_nxt;
    end
  end

  assign res.line_end     = is_end;
  assign res.port_action  = act;
  assign res.led_mode     = mode_nxt;
  assign res.mode_changed = changed;

  a_changed_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    res.mode_changed |-> res.line_end)
    else $error("mode change without line end");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_end |=> (cnt_r == '0) && (sm_r == ALL_FLAGS))
    else $error("line state not cleared after line end");

  a_mode_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(mode_r) && $stable(cnt_r) && $stable(sm_r))
    else $error("state moved without an item");

  a_no_change_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !is_end |=> $stable(mode_r))
    else $error("mode moved on an ordinary character");
endmodule

### sv/ulkd_out_reg.sv
// Result register: holds one decoded item until the sink takes it.
module ulkd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  ulkd_pkg::res_t res,
  output logic           adv,
  ulkd_out_if.source     out_ch
);
  import ulkd_pkg::*;

  logic vld_r, vld_nxt;
  res_t res_r;

  // Advance when the result slot is empty or is being drained this cycle.
  assign adv     = in_vld && (!vld_r || out_ch.ready);
  assign vld_nxt = adv || (vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.line_end     = res_r.line_end;
  assign out_ch.port_action  = res_r.port_action;
  assign out_ch.led_mode     = res_r.led_mode;
  assign out_ch.mode_changed = res_r.mode_changed;
endmodule

### sv/uart_line_keyword_decoder.sv
// Top level of the UART line keyword decoder.
// Takes one received byte per item and returns one result item per byte, one item
// per cycle sustained while out_if is ready. Each byte passes an input register,
// then the combinational keyword flag update and line-end evaluation, then the
// result register, from which the result item shows on out_if until it is taken.
// Carriage return or line feed ends a line; the line is then checked against the
// ten keywords (last match wins), giving the all-on/all-off request and the held
// mode 0..7. Lines longer than 31 characters count as 31. Backpressure on out_if
// stalls both stages.
module uart_line_keyword_decoder (
  input  logic       clk,
  input  logic       rst_n,
  ulkd_in_if.sink    in_if,
  ulkd_out_if.source out_if
);
  import ulkd_pkg::*;

  logic       in_vld;
  logic [7:0] byte_q;
  logic       adv;
  res_t       res;

  ulkd_in_reg u_in_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .adv    (adv),
    .vld    (in_vld),
    .byte_q (byte_q)
  );

  ulkd_match u_match (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .byte_q (byte_q),
    .res    (res)
  );

  ulkd_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_vld),
    .res    (res),
    .adv    (adv),
    .out_ch (out_if)
  );
endmodule
